>>> hw/rtl/aht_pkg.sv
// Package for the averaged hysteresis thermostat: widths, constants,
// register codes and the structs shared between the core's modules.
// No dependencies.
package aht_pkg;

   localparam int ADC_W = 10;
   localparam int SUM_W = 16;
   localparam int TEMP_W = 17;
   localparam int HYST_W = 10;
   localparam int LOCK_W = 20;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam int WINDOW_DEFAULT = 60;

   // average = floor(sum * PRODUCT_SCALE / (2^PRE_SHIFT * WINDOW)) - TEMP_OFFSET
   localparam int PRODUCT_SCALE = 55800;
   localparam int PRE_SHIFT = 10;
   localparam int PROD_W = 32;
   localparam int PRE_W = PROD_W - PRE_SHIFT;
   // exact reciprocal divide for dividends below 2^PRE_W and divisors up to 64
   localparam int DIV_SHIFT = 28;
   localparam int RECIP_W = DIV_SHIFT + 1;
   localparam int QUOT_W = 16;
   localparam int TEMP_OFFSET = 5800;

   localparam logic [LOCK_W-1:0] SINCE_MAX = '1;

   localparam logic signed [TEMP_W-1:0] SETPOINT_RESET = 17'sd7350;
   localparam logic [HYST_W-1:0] HYSTERESIS_RESET = 10'd5;
   localparam logic signed [TEMP_W-1:0] FAILSAFE_RESET = 17'sd100;
   localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 20'd300000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SETPOINT,
      CSR_HYSTERESIS,
      CSR_FAILSAFE,
      CSR_POWER,
      CSR_COOL,
      CSR_LOCKOUT
   } csr_index_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] setpoint;
      logic [HYST_W-1:0] hysteresis;
      logic signed [TEMP_W-1:0] failsafe;
      logic power_enable;
      logic cool_mode;
      logic [LOCK_W-1:0] lockout;
   } cfg_type;

   // advN: the item in stage N moves on at this edge
   typedef struct packed {
      logic accept;
      logic adv1;
      logic adv2;
      logic adv3;
      logic adv4;
   } pipe_ctrl_type;

endpackage

>>> hw/rtl/aht_if.sv
// Channel interfaces of the averaged hysteresis thermostat core.
// Depends on aht_pkg.
interface aht_req_if import aht_pkg::*; ;
   logic valid;
   logic ready;
   logic kind;
   logic [ADC_W-1:0] adc_sample;

   modport source (output valid, output kind, output adc_sample, input ready);
   modport sink (input valid, input kind, input adc_sample, output ready);
endinterface

interface aht_rsp_if import aht_pkg::*; ;
   logic valid;
   logic ready;
   logic drive_on;
   logic drive_changed;
   logic signed [TEMP_W-1:0] average_temp_centi;
   logic sensor_fault;
   logic lockout_active;

   modport source (output valid, output drive_on, output drive_changed,
                   output average_temp_centi, output sensor_fault,
                   output lockout_active, input ready);
   modport sink (input valid, input drive_on, input drive_changed,
                 input average_temp_centi, input sensor_fault,
                 input lockout_active, output ready);
endinterface

>>> hw/rtl/averaged_hysteresis_thermostat_core.sv
// Averaged hysteresis thermostat core: top level.
// Depends on aht_pkg, aht_if, aht_sample_ring, aht_scale and aht_control.
//
// Each request transfer is either a 10-bit temperature sample (kind 0) or a
// 1 ms tick (kind 1), and each one yields exactly one response transfer. The
// core sustains one item per clock: a new request is taken every cycle while
// the response side keeps up, and each item passes stages 1 to 4 and then the
// response register. Samples go into a WINDOW-entry ring memory (one read port
// used at request transfer, one write port as the sample leaves stage 1);
// the running sum is updated by read-modify-write with a bypass for an entry
// written in the same cycle it is read, and entries never written since reset
// read as zero, so no clearing pass is needed. The sum is scaled to hundredths
// of a degree F over two multiplier stages, then the heat/cool decision, the
// fail-safe check and the cooler restart lockout are evaluated in the last
// stage, which loads the response register. Stalled stages hold and empty ones
// fill, so a stalled response still lets up to four further items enter. Write
// the csr_ registers only while no item is in flight.
module averaged_hysteresis_thermostat_core import aht_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   aht_req_if.sink req_chan,
   aht_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   pipe_ctrl_type ctrl;

   logic v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic free1, free2, free3, free4;

   logic s2_kind, s4_kind;
   logic [SUM_W-1:0] s2_sum;
   logic [QUOT_W-1:0] s4_quot;

   // Configuration write decode; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT:   cfg_in.setpoint = signed'(csr_wdata[TEMP_W-1:0]);
            CSR_HYSTERESIS: cfg_in.hysteresis = csr_wdata[HYST_W-1:0];
            CSR_FAILSAFE:   cfg_in.failsafe = signed'(csr_wdata[TEMP_W-1:0]);
            CSR_POWER:      cfg_in.power_enable = csr_wdata[0];
            CSR_COOL:       cfg_in.cool_mode = csr_wdata[0];
            CSR_LOCKOUT:    cfg_in.lockout = csr_wdata[LOCK_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint <= SETPOINT_RESET;
         cfg_ff.hysteresis <= HYSTERESIS_RESET;
         cfg_ff.failsafe <= FAILSAFE_RESET;
         cfg_ff.power_enable <= 1'b0;
         cfg_ff.cool_mode <= 1'b0;
         cfg_ff.lockout <= LOCKOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline flow: a stage advances when the next one is empty or advancing.
   always_comb begin
      ctrl.adv4 = v4_ff && (!vo_ff || rsp_chan.ready);
      free4 = !v4_ff || ctrl.adv4;
      ctrl.adv3 = v3_ff && free4;
      free3 = !v3_ff || ctrl.adv3;
      ctrl.adv2 = v2_ff && free3;
      free2 = !v2_ff || ctrl.adv2;
      ctrl.adv1 = v1_ff && free2;
      free1 = !v1_ff || ctrl.adv1;
      ctrl.accept = req_chan.valid && free1;
   end

   assign req_chan.ready = free1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.accept || (v1_ff && !ctrl.adv1);
         v2_ff <= ctrl.adv1 || (v2_ff && !ctrl.adv2);
         v3_ff <= ctrl.adv2 || (v3_ff && !ctrl.adv3);
         v4_ff <= ctrl.adv3 || (v4_ff && !ctrl.adv4);
         vo_ff <= ctrl.adv4 || (vo_ff && !rsp_chan.ready);
      end
   end

   aht_sample_ring #(.WINDOW(WINDOW)) u_ring (
      .clock(clock),
      .reset(reset),
      .ctrl(ctrl),
      .in_kind(req_chan.kind),
      .in_sample(req_chan.adc_sample),
      .s2_kind(s2_kind),
      .s2_sum(s2_sum)
   );

   aht_scale #(.WINDOW(WINDOW)) u_scale (
      .clock(clock),
      .ctrl(ctrl),
      .s2_kind(s2_kind),
      .s2_sum(s2_sum),
      .s4_kind(s4_kind),
      .s4_quot(s4_quot)
   );

   aht_control u_control (
      .clock(clock),
      .reset(reset),
      .ctrl(ctrl),
      .cfg(cfg_ff),
      .s4_kind(s4_kind),
      .s4_quot(s4_quot),
      .drive_on(rsp_chan.drive_on),
      .drive_changed(rsp_chan.drive_changed),
      .average_temp_centi(rsp_chan.average_temp_centi),
      .sensor_fault(rsp_chan.sensor_fault),
      .lockout_active(rsp_chan.lockout_active)
   );

   assign rsp_chan.valid = vo_ff;

endmodule

>>> hw/rtl/aht_sample_ring.sv
// Sample ring memory with read-modify-write of the running sum.
// Holds pipeline stages 1 and 2. Depends on aht_pkg.
module aht_sample_ring import aht_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  pipe_ctrl_type ctrl,
   input  logic in_kind,
   input  logic [ADC_W-1:0] in_sample,
   output logic s2_kind,
   output logic [SUM_W-1:0] s2_sum
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   logic [ADC_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0] valid_ff;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;

   logic s1_kind_ff;
   logic [ADC_W-1:0] s1_sample_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [ADC_W-1:0] rd_data_ff;
   logic rd_ok_ff;
   logic fwd_ff;
   logic [ADC_W-1:0] fwd_data_ff;

   logic s2_kind_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [ADC_W-1:0] old_sample;
   logic s1_write;

   assign s1_write = ctrl.adv1 && !s1_kind_ff;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      if (ctrl.accept && !in_kind) begin
         wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
      end
   end

   // never-written entries read as zero; bypass an entry written this edge
   always_comb begin
      if (fwd_ff) begin
         old_sample = fwd_data_ff;
      end else if (rd_ok_ff) begin
         old_sample = rd_data_ff;
      end else begin
         old_sample = '0;
      end
      sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(s1_sample_ff);
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         ring_mem[s1_idx_ff] <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         rd_data_ff <= ring_mem[wr_idx_ff];
         rd_ok_ff <= valid_ff[wr_idx_ff];
         fwd_ff <= s1_write && (s1_idx_ff == wr_idx_ff);
         fwd_data_ff <= s1_sample_ff;
         s1_kind_ff <= in_kind;
         s1_sample_ff <= in_sample;
         s1_idx_ff <= wr_idx_ff;
      end
      if (ctrl.adv1) begin
         s2_kind_ff <= s1_kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wr_idx_ff <= '0;
         sum_ff <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         if (s1_write) begin
            valid_ff[s1_idx_ff] <= 1'b1;
            sum_ff <= sum_in;
         end
      end
   end

   assign s2_kind = s2_kind_ff;
   assign s2_sum = sum_ff;

endmodule

>>> hw/rtl/aht_scale.sv
// Fixed-point conversion of the running sum to an unsigned temperature
// quotient, stages 3 and 4. Depends on aht_pkg.
module aht_scale import aht_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic clock,
   input  pipe_ctrl_type ctrl,
   input  logic s2_kind,
   input  logic [SUM_W-1:0] s2_sum,
   output logic s4_kind,
   output logic [QUOT_W-1:0] s4_quot
);

   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** DIV_SHIFT + WINDOW - 1) / WINDOW);
   localparam logic [PROD_W-1:0] SCALE = PROD_W'(PRODUCT_SCALE);

   logic s3_kind_ff, s4_kind_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [QUOT_W-1:0] quot_ff;
   logic [PRE_W+RECIP_W-1:0] recip_prod;

   assign prod_in = PROD_W'(s2_sum) * SCALE;
   assign recip_prod = (PRE_W+RECIP_W)'(prod_ff[PROD_W-1:PRE_SHIFT])
                     * (PRE_W+RECIP_W)'(RECIP);

   always_ff @(posedge clock) begin
      if (ctrl.adv2) begin
         prod_ff <= prod_in;
         s3_kind_ff <= s2_kind;
      end
      if (ctrl.adv3) begin
         quot_ff <= recip_prod[DIV_SHIFT +: QUOT_W];
         s4_kind_ff <= s3_kind_ff;
      end
   end

   assign s4_kind = s4_kind_ff;
   assign s4_quot = quot_ff;

endmodule

>>> hw/rtl/aht_control.sv
// Thermostat decision with lockout counter and the result register.
// Depends on aht_pkg.
module aht_control import aht_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  pipe_ctrl_type ctrl,
   input  cfg_type cfg,
   input  logic s4_kind,
   input  logic [QUOT_W-1:0] s4_quot,
   output logic drive_on,
   output logic drive_changed,
   output logic signed [TEMP_W-1:0] average_temp_centi,
   output logic sensor_fault,
   output logic lockout_active
);

   logic drive_ff, drive_in;
   logic prev_ff, prev_in;
   logic [LOCK_W-1:0] since_ff, since_in, since_tick;

   logic changed_ff;
   logic signed [TEMP_W-1:0] avg_ff, avg;
   logic fault_ff, fault;
   logic lock_ff;

   logic signed [TEMP_W:0] avg_x, sp_x, lo_x, hi_x;
   logic lock_done;

   always_comb begin
      avg = TEMP_W'(signed'({1'b0, s4_quot})) - TEMP_W'(TEMP_OFFSET);
      avg_x = (TEMP_W+1)'(avg);
      sp_x = (TEMP_W+1)'(cfg.setpoint);
      lo_x = sp_x - (TEMP_W+1)'(signed'({1'b0, cfg.hysteresis}));
      hi_x = sp_x + (TEMP_W+1)'(signed'({1'b0, cfg.hysteresis}));
      fault = avg < cfg.failsafe;
      // advance the counter on a tick, saturating
      since_tick = (s4_kind && since_ff != SINCE_MAX) ? since_ff + 1'b1 : since_ff;
      lock_done = since_tick >= cfg.lockout;

      drive_in = drive_ff;
      prev_in = prev_ff;
      since_in = since_tick;
      if (!fault) begin
         if (cfg.power_enable) begin
            if (!cfg.cool_mode) begin
               drive_in = avg_x <= lo_x;
            end else if (avg_x >= hi_x && lock_done) begin
               drive_in = 1'b1;
            end else if (avg_x <= sp_x) begin
               drive_in = 1'b0;
               if (prev_ff) begin
                  since_in = '0;
               end
            end
         end else begin
            drive_in = 1'b0;
            if (prev_ff) begin
               since_in = '0;
            end
         end
         prev_in = drive_in;
      end else begin
         drive_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= 1'b0;
         prev_ff <= 1'b0;
         since_ff <= '0;
      end else if (ctrl.adv4) begin
         drive_ff <= drive_in;
         prev_ff <= prev_in;
         since_ff <= since_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv4) begin
         changed_ff <= drive_in != drive_ff;
         avg_ff <= avg;
         fault_ff <= fault;
         lock_ff <= since_in < cfg.lockout;
      end
   end

   assign drive_on = drive_ff;
   assign drive_changed = changed_ff;
   assign average_temp_centi = avg_ff;
   assign sensor_fault = fault_ff;
   assign lockout_active = lock_ff;

endmodule

>>> hw/rtl/aht_checker.sv
// Port-level assertions for the averaged hysteresis thermostat core, and the
// bind that attaches them. Depends on aht_pkg and aht_if.
module aht_checker import aht_pkg::*; (
   input logic clock,
   input logic reset,
   aht_req_if.sink req_chan,
   aht_rsp_if.source rsp_chan
);

   localparam int DEPTH = 5;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic last_drive_ff;
   logic in_xfer, out_xfer;

   assign in_xfer = req_chan.valid && req_chan.ready;
   assign out_xfer = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (in_xfer && !out_xfer) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (out_xfer && !in_xfer) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         last_drive_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (out_xfer) begin
            last_drive_ff <= rsp_chan.drive_on;
         end
      end
   end

   // no response without an outstanding request, and never more in flight
   // than the pipeline holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (cnt_ff != '0) && (cnt_ff <= CNT_W'(DEPTH)))
      else $error("response without matching request or pipeline overfilled");

   // drive_changed tracks the previously delivered drive_on
   assert property (@(posedge clock) disable iff (reset)
      out_xfer |-> rsp_chan.drive_changed == (rsp_chan.drive_on != last_drive_ff))
      else $error("drive_changed disagrees with previous drive_on");

   // a sensor fault forces the drive off
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.sensor_fault |-> !rsp_chan.drive_on)
      else $error("drive on during sensor fault");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid
         && $stable(rsp_chan.drive_on) && $stable(rsp_chan.drive_changed)
         && $stable(rsp_chan.average_temp_centi) && $stable(rsp_chan.sensor_fault)
         && $stable(rsp_chan.lockout_active))
      else $error("stalled response changed");

endmodule

bind averaged_hysteresis_thermostat_core aht_checker u_aht_checker (
   .clock(clock),
   .reset(reset),
   .req_chan(req_chan),
   .rsp_chan(rsp_chan)
);

>>> tb/thermostat_checker.sv
`timescale 1ns / 1ps
// Response checker for the averaged hysteresis thermostat core: tracks register writes,
// predicts one response per request transfer and compares each response field by field.
// Depends on aht_pkg and the channel interfaces in aht_if.
module thermostat_checker import aht_pkg::*; (
   input  logic clock,
   input  logic reset,
   aht_req_if req_mon,
   aht_rsp_if rsp_mon,
   input  logic csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int mismatch_count,
   output int results_outstanding,
   output int avg_now
);

   localparam int WINDOW = WINDOW_DEFAULT;
   localparam int SINCE_LIMIT = (1 << LOCK_W) - 1;

   typedef struct packed {
      logic drive_on;
      logic drive_changed;
      logic signed [TEMP_W-1:0] avg;
      logic sensor_fault;
      logic lockout_active;
   } thermo_result_type;

   thermo_result_type pending_results[$];

   // thermostat state
   logic [ADC_W-1:0] ring_mem [0:63];
   int ring_pos;
   int ring_sum;
   int since_off_ms;
   logic drive;
   logic prev_setting;
   logic last_drive;

   // register copies
   int setpoint;
   int hysteresis;
   int failsafe;
   int lockout;
   logic power_on;
   logic cooling;

   function automatic thermo_result_type next_thermostat_result(input logic kind,
                                                                input logic [ADC_W-1:0] sample);
      thermo_result_type r;
      int pos;
      int avg;
      logic fault;
      if (!kind) begin
         pos = (ring_pos >= WINDOW) ? 0 : ring_pos;
         ring_sum = ring_sum - int'(ring_mem[pos]) + int'(sample);
         ring_mem[pos] = sample;
         pos++;
         ring_pos = (pos >= WINDOW) ? 0 : pos;
      end else if (since_off_ms < SINCE_LIMIT) begin
         since_off_ms++;
      end

      avg = int'((longint'(ring_sum) * PRODUCT_SCALE) / (longint'(1024) * WINDOW))
            - TEMP_OFFSET;
      fault = (avg < failsafe);

      if (!fault) begin
         if (power_on) begin
            if (!cooling) begin
               drive = (avg <= setpoint - hysteresis);
            end else if (avg >= setpoint + hysteresis && since_off_ms >= lockout) begin
               // turn-on wins when both thresholds meet
               drive = 1'b1;
            end else if (avg <= setpoint) begin
               drive = 1'b0;
               if (prev_setting) since_off_ms = 0;
            end
         end else begin
            drive = 1'b0;
            if (prev_setting) since_off_ms = 0;
         end
         prev_setting = drive;
      end else begin
         // hold prev_setting on a fault; the lockout timer still counts ticks
         drive = 1'b0;
      end

      r.drive_on = drive;
      r.drive_changed = (drive != last_drive);
      r.avg = TEMP_W'(avg);
      r.sensor_fault = fault;
      r.lockout_active = (since_off_ms < lockout);
      last_drive = drive;
      avg_now = avg;
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [TEMP_W-1:0] want_v,
                              input logic signed [TEMP_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      thermo_result_type want;
      if (reset) begin
         for (int i = 0; i < 64; i++) ring_mem[i] = '0;
         ring_pos = 0;
         ring_sum = 0;
         since_off_ms = 0;
         drive = 1'b0;
         prev_setting = 1'b0;
         last_drive = 1'b0;
         setpoint = int'(SETPOINT_RESET);
         hysteresis = int'(HYSTERESIS_RESET);
         failsafe = int'(FAILSAFE_RESET);
         lockout = int'(LOCKOUT_RESET);
         power_on = 1'b0;
         cooling = 1'b0;
         pending_results.delete();
         mismatch_count = 0;
         avg_now = -TEMP_OFFSET;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SETPOINT:   setpoint = int'($signed(csr_wdata[TEMP_W-1:0]));
               CSR_HYSTERESIS: hysteresis = int'(csr_wdata[HYST_W-1:0]);
               CSR_FAILSAFE:   failsafe = int'($signed(csr_wdata[TEMP_W-1:0]));
               CSR_POWER:      power_on = csr_wdata[0];
               CSR_COOL:       cooling = csr_wdata[0];
               CSR_LOCKOUT:    lockout = int'(csr_wdata[LOCK_W-1:0]);
               default: ;
            endcase
         end

         // a response always belongs to an earlier request, so compare first
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $error("response transfer with no request waiting for it");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("drive_on", TEMP_W'(want.drive_on),
                           TEMP_W'(rsp_mon.drive_on));
               check_field("drive_changed", TEMP_W'(want.drive_changed),
                           TEMP_W'(rsp_mon.drive_changed));
               check_field("average_temp_centi", want.avg, rsp_mon.average_temp_centi);
               check_field("sensor_fault", TEMP_W'(want.sensor_fault),
                           TEMP_W'(rsp_mon.sensor_fault));
               check_field("lockout_active", TEMP_W'(want.lockout_active),
                           TEMP_W'(rsp_mon.lockout_active));
            end
         end

         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(next_thermostat_result(req_mon.kind, req_mon.adc_sample));
      end
      results_outstanding = pending_results.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the thermostat core testbench: clock, reset, register setup, request and
// response stimulus with random idling, and the final verdict.
// Depends on aht_pkg, aht_if, the core and thermostat_checker.
module tb_top;
   import aht_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 10;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int TEMP_MIN = -5800;
   localparam int TEMP_MAX = 49950;
   localparam int LOCKOUT_MAX = 600000;
   localparam int HYST_MAX = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int results_outstanding;
   int avg_now;
   int cycle_count = 0;

   // Knobs shared between the stimulus processes.
   bit tx_calm = 1'b1;     // sender offers back to back
   bit rx_calm = 1'b0;     // receiver takes no random gaps
   bit hold_req = 1'b0;    // ask the receiver for one long hold-off

   aht_req_if req_chan ();
   aht_rsp_if rsp_chan ();

   averaged_hysteresis_thermostat_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   thermostat_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_chan),
      .rsp_mon             (rsp_chan),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding),
      .avg_now             (avg_now)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Stop a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Idle length: mostly short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request and hold it until the transfer. Ready is sampled at the
   // falling edge, where it has settled, and the transfer lands on the next rising
   // edge. Leave valid high for a back-to-back follower, else drop it for a gap.
   task automatic send_item(input logic kind, input logic [ADC_W-1:0] sample);
      bit took;
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.adc_sample <= sample;
      do begin
         @(negedge clock);
         took = req_chan.ready;
         @(posedge clock);
      end while (!took);
      if (!tx_calm && $urandom_range(0, 99) < 45) begin
         gap = idle_length();
         req_chan.valid <= 1'b0;
         req_chan.kind <= 1'($urandom);
         req_chan.adc_sample <= ADC_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted response has arrived, then let
   // the pipeline run empty before touching the registers.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (results_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic apply_config(input int sp, input int hy, input int fs, input logic pw,
                               input logic cl, input int lk);
      write_csr(CSR_SETPOINT, sp);
      write_csr(CSR_HYSTERESIS, hy);
      write_csr(CSR_FAILSAFE, fs);
      write_csr(CSR_POWER, int'(pw));
      write_csr(CSR_COOL, int'(cl));
      write_csr(CSR_LOCKOUT, lk);
      csr_we <= 1'b0;
   endtask

   // Response side: random ready runs and gaps, plus one long hold-off on request
   // counted here so the sender keeps pushing and the core backs up into its input.
   initial begin
      int run_left;
      int gap_left;
      int hold_left;
      run_left = 0;
      gap_left = 0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (run_left == 0 && gap_left == 0) begin
               run_left = $urandom_range(1, 24);
               gap_left = (rx_calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
            end
            if (run_left > 0) begin
               run_left--;
               rsp_chan.ready <= 1'b1;
            end else begin
               gap_left--;
               rsp_chan.ready <= 1'b0;
            end
         end
      end
   end

   // Main stimulus.
   initial begin
      int sent;
      int len;
      int phase;
      int center;
      int sample;
      int sp;
      int hy;
      int fs;
      int lk;
      logic pw;
      logic cl;
      int r;

      req_chan.valid = 1'b0;
      req_chan.kind = 1'b0;
      req_chan.adc_sample = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- Directed part ----
      // Out of reset the ring is empty, the average sits at its floor and the
      // default fail-safe threshold forces the drive off.
      tx_calm = 1'b1;
      send_item(1'b0, 10'h000);
      send_item(1'b0, 10'h3FF);
      send_item(1'b1, 10'h155);
      send_item(1'b0, 10'h2AA);
      drain_results();

      // Disable the fault check and power up in heat mode: a low average calls
      // for heat.
      write_csr(CSR_FAILSAFE, TEMP_MIN);
      write_csr(CSR_POWER, 1);
      csr_we <= 1'b0;
      send_item(1'b0, 10'h3FF);
      send_item(1'b1, 10'h000);
      send_item(1'b0, 10'h000);
      drain_results();

      // Cool mode with no hysteresis and the setpoint right on the average: both
      // thresholds meet, and turn-on waits for the short lockout to run out.
      write_csr(CSR_COOL, 1);
      write_csr(CSR_LOCKOUT, 3);
      write_csr(CSR_HYSTERESIS, 0);
      write_csr(CSR_SETPOINT, avg_now);
      csr_we <= 1'b0;
      repeat (4) send_item(1'b1, ADC_W'($urandom));
      drain_results();

      // Raise the setpoint to the top: the cooler shuts off and restarts the lockout.
      write_csr(CSR_SETPOINT, TEMP_MAX);
      csr_we <= 1'b0;
      send_item(1'b1, 10'h000);
      send_item(1'b1, 10'h3FF);
      drain_results();

      // Lockout of zero: the cooler comes straight back on.
      write_csr(CSR_SETPOINT, avg_now);
      write_csr(CSR_LOCKOUT, 0);
      csr_we <= 1'b0;
      send_item(1'b1, 10'h000);
      drain_results();

      // Power off while running: drive falls and the lockout timer restarts.
      write_csr(CSR_POWER, 0);
      csr_we <= 1'b0;
      send_item(1'b1, 10'h000);
      send_item(1'b0, 10'h3FF);
      drain_results();

      // Fail-safe at its top: every average counts as a sensor fault.
      write_csr(CSR_FAILSAFE, TEMP_MAX);
      write_csr(CSR_POWER, 1);
      csr_we <= 1'b0;
      send_item(1'b0, 10'h000);
      send_item(1'b1, 10'h3FF);
      drain_results();

      // Longest lockout: the cooler stays locked out.
      write_csr(CSR_FAILSAFE, TEMP_MIN);
      write_csr(CSR_LOCKOUT, LOCKOUT_MAX);
      write_csr(CSR_HYSTERESIS, HYST_MAX);
      write_csr(CSR_SETPOINT, TEMP_MIN);
      csr_we <= 1'b0;
      send_item(1'b1, 10'h000);
      send_item(1'b0, 10'h1FF);
      drain_results();

      // ---- Random part ----
      // Each phase: drain, pick a fresh register setting around the current
      // average, then stream samples wandering around a center plus ticks.
      sent = 0;
      phase = 0;
      center = 400;
      while (sent < RANDOM_ITEMS) begin
         drain_results();

         r = $urandom_range(0, 9);
         if (r < 8) sp = clamp_int(avg_now + int'($urandom_range(0, 600)) - 300,
                                   TEMP_MIN, TEMP_MAX);
         else if (r == 8) sp = TEMP_MIN;
         else sp = TEMP_MAX;

         r = $urandom_range(0, 9);
         if (r == 0) hy = 0;
         else if (r == 1) hy = HYST_MAX;
         else if (r == 2) hy = $urandom_range(0, HYST_MAX);
         else hy = $urandom_range(0, 40);

         r = $urandom_range(0, 9);
         if (r < 7) fs = TEMP_MIN;
         else if (r == 7) fs = TEMP_MAX;
         else if (r == 8) fs = clamp_int(avg_now + int'($urandom_range(0, 200)) - 100,
                                         TEMP_MIN, TEMP_MAX);
         else fs = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));

         r = $urandom_range(0, 19);
         if (r < 12) lk = $urandom_range(0, 30);
         else if (r < 15) lk = 0;
         else if (r < 17) lk = $urandom_range(0, 200);
         else if (r < 19) lk = $urandom_range(0, LOCKOUT_MAX);
         else lk = LOCKOUT_MAX;

         pw = ($urandom_range(0, 99) < 85);
         cl = 1'($urandom);
         apply_config(sp, hy, fs, pw, cl, lk);

         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            // back the core up: receiver holds off while the sender keeps offering
            tx_calm = 1'b1;
            hold_req = 1'b1;
         end

         if ($urandom_range(0, 4) == 0) center = $urandom_range(0, 1023);
         else center = clamp_int(center + int'($urandom_range(0, 60)) - 30, 0, 1023);

         len = $urandom_range(40, 160);
         repeat (len) begin
            if ($urandom_range(0, 99) < 35) begin
               send_item(1'b1, ADC_W'($urandom));
            end else begin
               if ($urandom_range(0, 9) == 0) sample = $urandom_range(0, 1023);
               else sample = clamp_int(center + int'($urandom_range(0, 16)) - 8, 0, 1023);
               send_item(1'b0, ADC_W'(sample));
            end
            if ($urandom_range(0, 7) == 0)
               center = clamp_int(center + int'($urandom_range(0, 6)) - 3, 0, 1023);
         end
         sent += len;
         phase++;
      end

      drain_results();

      if (mismatch_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/aht_pkg.sv
hw/rtl/aht_if.sv
hw/rtl/aht_sample_ring.sv
hw/rtl/aht_scale.sv
hw/rtl/aht_control.sv
hw/rtl/averaged_hysteresis_thermostat_core.sv
hw/rtl/aht_checker.sv
tb/thermostat_checker.sv
tb/tb_top.sv
